>>> hdl/mapm_pkg.sv
// Shared types, constants and helper functions for the medial axis pixel marker.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package mapm_pkg;

    // Field widths of the pixel stream.
    localparam int COORD_W    = 10;
    localparam int DIST_W     = 16;
    localparam int INT_W      = 8;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Grid and slot limits of this build.
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS     = 1024;
    localparam int MAX_CONTOURS = 4;
    localparam int DIST_SLOTS   = 4;
    localparam int NUM_PAIRS    = 6;
    localparam int PAIR_IDX_W   = 3;
    localparam int SLOT_IDX_W   = 2;
    localparam int LIMIT_W      = 13;

    localparam int SLOT_LIMIT_I =
        (MAX_CONTOURS < DIST_SLOTS) ? MAX_CONTOURS : DIST_SLOTS;
    localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(SLOT_LIMIT_I);
    localparam logic [LIMIT_W-1:0] ROW_LIMIT  = LIMIT_W'(MAX_ROWS);
    localparam logic [LIMIT_W-1:0] COL_LIMIT  = LIMIT_W'(MAX_COLS);

    // Two integer parts this close count as equidistant.
    localparam logic [INT_W-1:0] INT_MARGIN = 8'd1;

    // Configuration register indexes and reset values.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CONTOUR_COUNT = 4'd0;
    localparam cfg_idx_t CFG_NEAR_LIMIT    = 4'd1;
    localparam logic [COUNT_W-1:0] CONTOUR_COUNT_RESET = 3'd0;
    localparam logic [DIST_W-1:0]  NEAR_LIMIT_RESET    = 16'd512;

    // Result of the compare stage: per pair and per slot flags.
    typedef struct packed {
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
        logic [NUM_PAIRS-1:0]  active;
        logic [NUM_PAIRS-1:0]  close;
        logic [DIST_SLOTS-1:0] near;
        logic                  oob;
    } mapm_eval_t;

    // Compare result plus the running mark (clear means mark is 0).
    typedef struct packed {
        mapm_eval_t ev;
        logic       clear;
    } mapm_mark_t;

    // First slot of each pair, in visiting order.
    function automatic logic [SLOT_IDX_W-1:0] pair_a(input logic [PAIR_IDX_W-1:0] p);
        logic [SLOT_IDX_W-1:0] r;
        case (p)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd0;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Second slot of each pair, in visiting order.
    function automatic logic [SLOT_IDX_W-1:0] pair_b(input logic [PAIR_IDX_W-1:0] p);
        logic [SLOT_IDX_W-1:0] r;
        case (p)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd3;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd3;
            3'd5:    r = 2'd3;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // One pair visit: a close pair clears the mark, a near pair restores it.
    function automatic logic mark_step(input logic clear, input logic active,
                                       input logic close, input logic near_any);
        logic r;
        r = clear;
        if (active) begin
            if (close)
                r = 1'b1;
            else if (clear && near_any)
                r = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/mapm_if.sv
// Handshake channel interfaces of the medial axis pixel marker.
// Depends on mapm_pkg for the field widths.
`timescale 1ns / 1ps

// Pixel item channel.
interface mapm_pix_if;
    logic                            valid;
    logic                            ready;
    logic [mapm_pkg::COORD_W-1:0]    row;
    logic [mapm_pkg::COORD_W-1:0]    col;
    logic [mapm_pkg::DIST_W-1:0]     dist_0;
    logic [mapm_pkg::DIST_W-1:0]     dist_1;
    logic [mapm_pkg::DIST_W-1:0]     dist_2;
    logic [mapm_pkg::DIST_W-1:0]     dist_3;

    modport source (output valid, row, col, dist_0, dist_1, dist_2, dist_3, input ready);
    modport sink   (input valid, row, col, dist_0, dist_1, dist_2, dist_3, output ready);
endinterface

// Result item channel.
interface mapm_res_if;
    logic                            valid;
    logic                            ready;
    logic [mapm_pkg::COORD_W-1:0]    point_x;
    logic [mapm_pkg::COORD_W-1:0]    point_y;
    logic                            on_axis;

    modport source (output valid, point_x, point_y, on_axis, input ready);
    modport sink   (input valid, point_x, point_y, on_axis, output ready);
endinterface

// Configuration write channel.
interface mapm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mapm_pkg::CFG_IDX_W-1:0]  index;
    logic [mapm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/mapm_eval.sv
// First pipeline stage: integer-part pair compares, near-limit compares and grid check.
// Depends on mapm_pkg.
`timescale 1ns / 1ps

module mapm_eval (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mapm_pkg::COORD_W-1:0]   row,
    input  logic [mapm_pkg::COORD_W-1:0]   col,
    input  logic [mapm_pkg::DIST_W-1:0]    dist_0,
    input  logic [mapm_pkg::DIST_W-1:0]    dist_1,
    input  logic [mapm_pkg::DIST_W-1:0]    dist_2,
    input  logic [mapm_pkg::DIST_W-1:0]    dist_3,
    input  logic [mapm_pkg::COUNT_W-1:0]   contour_count,
    input  logic [mapm_pkg::DIST_W-1:0]    near_limit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mapm_pkg::mapm_eval_t           out_data
);
    import mapm_pkg::*;

    logic [DIST_W-1:0]  slot_dist [DIST_SLOTS];
    logic [COUNT_W-1:0] slots;
    logic [INT_W-1:0]   ia;
    logic [INT_W-1:0]   ib;
    logic [INT_W-1:0]   diff;
    mapm_eval_t         data_next;
    mapm_eval_t         data_reg;
    logic               valid_next;
    logic               valid_reg;

    assign slot_dist[0] = dist_0;
    assign slot_dist[1] = dist_1;
    assign slot_dist[2] = dist_2;
    assign slot_dist[3] = dist_3;

    // Slot count saturated to what the build supports.
    assign slots = (contour_count > SLOT_LIMIT) ? SLOT_LIMIT : contour_count;

    // Pair and slot flags for one pixel.
    always_comb
    begin
        ia = '0;
        ib = '0;
        diff = '0;
        data_next.row = row;
        data_next.col = col;
        data_next.oob = ({3'b000, row} >= ROW_LIMIT) || ({3'b000, col} >= COL_LIMIT);
        for (int s = 0; s < DIST_SLOTS; s++)
        begin
            data_next.near[s] = (slot_dist[s] <= near_limit);
        end
        for (int p = 0; p < NUM_PAIRS; p++)
        begin
            ia = slot_dist[pair_a(PAIR_IDX_W'(p))][DIST_W-1:DIST_W-INT_W];
            ib = slot_dist[pair_b(PAIR_IDX_W'(p))][DIST_W-1:DIST_W-INT_W];
            diff = (ia >= ib) ? (ia - ib) : (ib - ia);
            data_next.close[p]  = (diff <= INT_MARGIN);
            data_next.active[p] = ({1'b0, pair_b(PAIR_IDX_W'(p))} < slots);
        end
    end

    // Stage handshake: load whenever the register is empty or draining.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/mapm_mark_front.sv
// Second pipeline stage: runs the mark through the three pairs that start at slot 0.
// Depends on mapm_pkg.
`timescale 1ns / 1ps

module mapm_mark_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mapm_pkg::mapm_eval_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mapm_pkg::mapm_mark_t out_data
);
    import mapm_pkg::*;

    localparam int FIRST_PAIR = 0;
    localparam int LAST_PAIR  = 2;

    mapm_mark_t data_next;
    mapm_mark_t data_reg;
    logic       valid_next;
    logic       valid_reg;
    logic       near_any;

    // The mark starts at 255, so the clear flag starts low.
    always_comb
    begin
        near_any = 1'b0;
        data_next.ev = in_data;
        data_next.clear = 1'b0;
        for (int p = FIRST_PAIR; p <= LAST_PAIR; p++)
        begin
            near_any = in_data.near[pair_a(PAIR_IDX_W'(p))] ||
                       in_data.near[pair_b(PAIR_IDX_W'(p))];
            data_next.clear = mark_step(data_next.clear, in_data.active[p],
                                        in_data.close[p], near_any);
        end
    end

    // Stage handshake.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/mapm_mark_back.sv
// Third pipeline stage: finishes the remaining pairs, applies the grid check and
// holds the result item in the output register. Depends on mapm_pkg.
`timescale 1ns / 1ps

module mapm_mark_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mapm_pkg::mapm_mark_t         in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mapm_pkg::COORD_W-1:0] point_x,
    output logic [mapm_pkg::COORD_W-1:0] point_y,
    output logic                         on_axis
);
    import mapm_pkg::*;

    localparam int FIRST_PAIR = 3;
    localparam int LAST_PAIR  = 5;

    logic               clear;
    logic               near_any;
    logic               valid_next;
    logic               valid_reg;
    logic [COORD_W-1:0] point_x_reg;
    logic [COORD_W-1:0] point_y_reg;
    logic               on_axis_reg;

    // Remaining pairs, then a pixel off the grid is never on the axis.
    always_comb
    begin
        near_any = 1'b0;
        clear = in_data.clear;
        for (int p = FIRST_PAIR; p <= LAST_PAIR; p++)
        begin
            near_any = in_data.ev.near[pair_a(PAIR_IDX_W'(p))] ||
                       in_data.ev.near[pair_b(PAIR_IDX_W'(p))];
            clear = mark_step(clear, in_data.ev.active[p], in_data.ev.close[p], near_any);
        end
    end

    // Output register handshake.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            point_x_reg <= in_data.ev.col;
            point_y_reg <= in_data.ev.row;
            on_axis_reg <= clear && !in_data.ev.oob;
        end
    end

    assign out_valid = valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign on_axis   = on_axis_reg;

endmodule

>>> hdl/medial_axis_pixel_marker.sv
// Top level of the medial axis pixel marker: configuration registers and the
// three-stage pixel pipeline. Depends on mapm_pkg, mapm_if and the mapm_* stages.
//
//   Channel  Direction  Carries
//   pix      in         row, col, dist_0 .. dist_3 (Q8.8)
//   res      out        point_x, point_y, on_axis
//   cfg      in         index, data (0: contour_count, 1: near_limit)
//
// One pixel item is taken every cycle while res accepts results; each result passes
// through the compare stage, the first pair stage and the output register in turn.
// The only backpressure path is the per-stage ready chain, so a stall on res holds
// each stage whose successor is full in place and loses or repeats nothing.
// Reset empties the pipeline and restores contour_count 0 and near_limit 512.
// The cfg channel is always ready; writes to unknown indexes are ignored.
`timescale 1ns / 1ps

module medial_axis_pixel_marker (
    input  logic              clk,
    input  logic              rst_n,
    mapm_pix_if.sink          pix,
    mapm_res_if.source        res,
    mapm_cfg_if.sink          cfg
);
    import mapm_pkg::*;

    logic [COUNT_W-1:0] contour_count_reg;
    logic [COUNT_W-1:0] contour_count_next;
    logic [DIST_W-1:0]  near_limit_reg;
    logic [DIST_W-1:0]  near_limit_next;
    logic               s1_valid;
    logic               s1_ready;
    mapm_eval_t         s1_data;
    logic               s2_valid;
    logic               s2_ready;
    mapm_mark_t         s2_data;

    // Configuration register writes.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        contour_count_next = contour_count_reg;
        near_limit_next    = near_limit_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CONTOUR_COUNT: contour_count_next = cfg.data[COUNT_W-1:0];
                CFG_NEAR_LIMIT:    near_limit_next    = cfg.data[DIST_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contour_count_reg <= CONTOUR_COUNT_RESET;
            near_limit_reg    <= NEAR_LIMIT_RESET;
        end
        else
        begin
            contour_count_reg <= contour_count_next;
            near_limit_reg    <= near_limit_next;
        end
    end

    // Stage one: compares.
    mapm_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pix.valid),
        .in_ready      (pix.ready),
        .row           (pix.row),
        .col           (pix.col),
        .dist_0        (pix.dist_0),
        .dist_1        (pix.dist_1),
        .dist_2        (pix.dist_2),
        .dist_3        (pix.dist_3),
        .contour_count (contour_count_reg),
        .near_limit    (near_limit_reg),
        .out_valid     (s1_valid),
        .out_ready     (s1_ready),
        .out_data      (s1_data)
    );

    // Stage two: pairs that start at slot 0.
    mapm_mark_front u_mark_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage three: remaining pairs and the output register.
    mapm_mark_back u_mark_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .point_x   (res.point_x),
        .point_y   (res.point_y),
        .on_axis   (res.on_axis)
    );

    // An accepted pixel always occupies the first stage on the next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> s1_valid)
        else $error("accepted pixel item did not reach the compare stage");

    // With fewer than two slots in use no pair is visited.
    a_no_pairs_off_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (contour_count_reg < 3'd2) |-> !res.on_axis)
        else $error("on_axis set with fewer than two contour slots");

    // A pixel outside the grid is never marked.
    a_off_grid_off_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (({3'b000, res.point_y} >= ROW_LIMIT) ||
                      ({3'b000, res.point_x} >= COL_LIMIT)) |-> !res.on_axis)
        else $error("on_axis set for a pixel outside the grid");

    // A stalled stage two holds its item until stage three takes it.
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
        else $error("stage two item changed while stalled");

endmodule
